>>> sv/cbrt_pkg.sv
// ----------------------------------------------------------------------------
// cbrt_pkg: shared constants, types and the root digit step
// Widths of the binary64 layout, the scaling constants for the exponent
// split, and one restoring cube-root digit step (one root bit per call).
// ----------------------------------------------------------------------------
package cbrt_pkg;

  localparam int STEPS   = 54;            // root bits: 53 significand + round
  localparam int ROOT_W  = STEPS;
  localparam int SQ_W    = 2 * ROOT_W;    // square of the partial root
  localparam int REM_W   = SQ_W + 4;      // partial remainder
  localparam int ACC_W   = REM_W + 3;     // remainder with the next digit
  localparam int NIN_W   = 57;            // scaled significand bits still to feed
  localparam int EXP_W   = 11;
  localparam int FRAC_W  = 52;
  localparam int MANT_W  = FRAC_W + 1;
  localparam int LZ_W    = 6;
  localparam int UB_W    = 12;            // biased exponent, offset to a multiple of 3
  localparam int PROD_W  = 24;
  localparam int RSH     = 13;            // shift of the reciprocal of three

  localparam logic [EXP_W-1:0]  EXP_MAX  = 11'h7FF;
  localparam logic [UB_W-1:0]   RECIP3   = 12'd2731;  // ceil(2^13 / 3)
  localparam logic [UB_W-1:0]   NORM_OFS = 12'd54;
  localparam logic [UB_W-1:0]   SUB_OFS  = 12'd55;
  localparam logic [EXP_W-1:0]  QB_OFS   = 11'd664;   // 1023 - 359

  typedef struct packed {
    logic [ROOT_W-1:0] y;   // partial root
    logic [SQ_W-1:0]   s;   // y squared
    logic [REM_W-1:0]  r;   // scaled operand prefix minus y cubed
  } root_acc_t;

  // One restoring step: try the next root bit as one.
  function automatic root_acc_t root_step(root_acc_t a, logic [2:0] d);
    logic [ACC_W-1:0] rs;
    logic [ACC_W-1:0] tr;
    logic [ACC_W-1:0] diff;
    root_acc_t        o;
    rs   = {a.r, d};
    tr   = (ACC_W'(a.s) << 3) + (ACC_W'(a.s) << 2) + (ACC_W'(a.y) << 2)
         + (ACC_W'(a.y) << 1) + ACC_W'(1);
    diff = rs - tr;
    if (rs >= tr) begin
      o.y = {a.y[ROOT_W-2:0], 1'b1};
      o.s = (a.s << 2) + (SQ_W'(a.y) << 2) + SQ_W'(1);
      o.r = diff[REM_W-1:0];
    end else begin
      o.y = {a.y[ROOT_W-2:0], 1'b0};
      o.s = a.s << 2;
      o.r = rs[REM_W-1:0];
    end
    return o;
  endfunction

endpackage

>>> sv/cube_root_double_rounded.sv
// ----------------------------------------------------------------------------
// cube_root_double_rounded: pipelined binary64 cube root, round to nearest
// Throughput: one request per cycle while the output skid stage is empty;
// one root bit is resolved per stage across 54 digit stages, after four
// stages of capture, unpacking and scaling, and before one output register.
// Reset (rst_n, synchronous, active low) clears all valid bits and the
// output skid stage; no data registers are cleared.
// ----------------------------------------------------------------------------
module cube_root_double_rounded (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_root_bits
);

  localparam int ST = cbrt_pkg::STEPS;

  logic en;

  // Unpack stage
  logic        v1_r;
  logic [63:0] op_r;

  // Classify stage
  logic                         v2_r;
  logic                         sgn2_r, spc2_r, sub2_r;
  logic [63:0]                  spv2_r;
  logic [cbrt_pkg::EXP_W-1:0]   exp2_r;
  logic [cbrt_pkg::FRAC_W-1:0]  frac2_r;
  logic [cbrt_pkg::LZ_W-1:0]    lz2_r;
  logic [cbrt_pkg::LZ_W-1:0]    lz_nxt;
  logic                         spc_nxt;
  logic [63:0]                  spv_nxt;

  // Normalize stage
  logic                         v3_r;
  logic                         sgn3_r, spc3_r;
  logic [63:0]                  spv3_r;
  logic [cbrt_pkg::MANT_W-1:0]  m3_r, m_nxt;
  logic [cbrt_pkg::UB_W-1:0]    u3_r, u_nxt;

  // Digit stages
  logic [ST:0]                  vld_r;
  logic                         sgn_r [ST+1];
  logic                         spc_r [ST+1];
  logic [63:0]                  spv_r [ST+1];
  logic [cbrt_pkg::EXP_W-1:0]   qb_r  [ST+1];
  logic [cbrt_pkg::NIN_W-1:0]   nin_r [ST+1];
  cbrt_pkg::root_acc_t          acc_r [ST+1];

  logic [cbrt_pkg::PROD_W-1:0]  prod;
  logic [cbrt_pkg::EXP_W-1:0]   q3;
  logic [cbrt_pkg::UB_W-1:0]    rem_full;
  logic [cbrt_pkg::MANT_W+1:0]  w_scaled;

  // Output and skid
  logic        out_valid_r, out_spec_r;
  logic [63:0] out_root_r;
  logic        skid_v_r, skid_spec_r;
  logic [63:0] skid_root_r;
  logic        inc_v;
  logic [63:0] inc_root;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      op_r <= in_operand_bits;
    end
  end

  // Find the leading one of the fraction and the special results
  always_comb begin
    lz_nxt = '0;
    for (int i = 0; i < cbrt_pkg::FRAC_W; i++) begin
      if (op_r[i]) lz_nxt = cbrt_pkg::LZ_W'(cbrt_pkg::FRAC_W - i);
    end
    spc_nxt = (op_r[62:52] == cbrt_pkg::EXP_MAX) || (op_r[62:0] == '0);
    spv_nxt = op_r;
    if (op_r[62:52] == cbrt_pkg::EXP_MAX && op_r[51:0] != '0) spv_nxt[51] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      sgn2_r  <= op_r[63];
      spc2_r  <= spc_nxt;
      spv2_r  <= spv_nxt;
      sub2_r  <= (op_r[62:52] == '0);
      exp2_r  <= op_r[62:52];
      frac2_r <= op_r[51:0];
      lz2_r   <= lz_nxt;
    end
  end

  // Normalize the significand and bias the exponent
  always_comb begin
    if (sub2_r) begin
      m_nxt = {1'b0, frac2_r} << lz2_r;
      u_nxt = cbrt_pkg::SUB_OFS - cbrt_pkg::UB_W'(lz2_r);
    end else begin
      m_nxt = {1'b1, frac2_r};
      u_nxt = cbrt_pkg::UB_W'(exp2_r) + cbrt_pkg::NORM_OFS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      sgn3_r <= sgn2_r;
      spc3_r <= spc2_r;
      spv3_r <= spv2_r;
      m3_r   <= m_nxt;
      u3_r   <= u_nxt;
    end
  end

  // Split the exponent into a multiple of three and a remainder
  always_comb begin
    prod     = cbrt_pkg::PROD_W'(u3_r) * cbrt_pkg::PROD_W'(cbrt_pkg::RECIP3);
    q3       = prod[cbrt_pkg::RSH +: cbrt_pkg::EXP_W];
    rem_full = u3_r - (cbrt_pkg::UB_W'(q3) << 1) - cbrt_pkg::UB_W'(q3);
    w_scaled = (cbrt_pkg::MANT_W+2)'(m3_r) << rem_full[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= v3_r;
    end
    if (en) begin
      sgn_r[0] <= sgn3_r;
      spc_r[0] <= spc3_r;
      spv_r[0] <= spv3_r;
      qb_r[0]  <= q3 + cbrt_pkg::QB_OFS;
      nin_r[0] <= {w_scaled, 2'b00};
      acc_r[0] <= '0;
    end
  end

  // Resolve one root bit per stage
  for (genvar k = 0; k < ST; k++) begin : g_digit
    cbrt_pkg::root_acc_t acc_nxt;
    assign acc_nxt = cbrt_pkg::root_step(acc_r[k],
                       nin_r[k][cbrt_pkg::NIN_W-1 -: 3]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        sgn_r[k+1] <= sgn_r[k];
        spc_r[k+1] <= spc_r[k];
        spv_r[k+1] <= spv_r[k];
        qb_r[k+1]  <= qb_r[k];
        nin_r[k+1] <= nin_r[k] << 3;
        acc_r[k+1] <= acc_nxt;
      end
    end
  end

  // Round to nearest even and pack
  always_comb begin
    logic                         sticky;
    logic                         rnd_up;
    logic [cbrt_pkg::MANT_W:0]    msum;
    logic [cbrt_pkg::MANT_W-1:0]  mant;
    logic [cbrt_pkg::EXP_W-1:0]   qb;
    sticky = |acc_r[ST].r;
    rnd_up = acc_r[ST].y[0] && (sticky || acc_r[ST].y[1]);
    msum   = {1'b0, acc_r[ST].y[ST-1:1]} + (cbrt_pkg::MANT_W+1)'(rnd_up);
    if (msum[cbrt_pkg::MANT_W]) begin
      mant = msum[cbrt_pkg::MANT_W:1];
      qb   = qb_r[ST] + cbrt_pkg::EXP_W'(1);
    end else begin
      mant = msum[cbrt_pkg::MANT_W-1:0];
      qb   = qb_r[ST];
    end
    inc_v    = en && vld_r[ST];
    inc_root = spc_r[ST] ? spv_r[ST] : {sgn_r[ST], qb, mant[cbrt_pkg::FRAC_W-1:0]};
  end

  // Hold the result, park one in the skid stage when stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (!out_valid_r || out_ready) begin
          out_valid_r <= 1'b1;
          skid_v_r    <= 1'b0;
        end
      end else if (inc_v) begin
        if (out_valid_r && !out_ready) begin
          skid_v_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (skid_v_r && (!out_valid_r || out_ready)) begin
      out_root_r <= skid_root_r;
      out_spec_r <= skid_spec_r;
    end else if (!skid_v_r && inc_v && (!out_valid_r || out_ready)) begin
      out_root_r <= inc_root;
      out_spec_r <= spc_r[ST];
    end
    if (!skid_v_r && inc_v && out_valid_r && !out_ready) begin
      skid_root_r <= inc_root;
      skid_spec_r <= spc_r[ST];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_root_bits = out_root_r;

`ifndef NO_ASSERTIONS
  // Skid stage is only used behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds a result while output is empty");

  // A result leaving the pipeline into a stalled output must be parked
  a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (inc_v && out_valid_r && !out_ready) |=> skid_v_r)
    else $error("result dropped while output stalled");

  // Cube root of a finite nonzero operand is always a normal number
  a_normal_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_spec_r) |->
      (out_root_r[62:52] != '0) && (out_root_r[62:52] != cbrt_pkg::EXP_MAX))
    else $error("non-special root left the normal range");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: binary64 cube root, round to nearest
// Drives raw binary64 operands through the valid/ready request channel and
// checks every root against an exact integer predictor (bit-by-bit root over
// wide vectors with a sticky bit). The receiver stalls at random and once
// holds off long enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WIDE_W      = 192;
  localparam int LONG_HOLD   = 300;
  localparam int WATCH_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 80;

  // Exact cube root of one binary64 bit pattern.
  function automatic logic [63:0] cbrt_round_nearest(logic [63:0] v);
    logic              sgn;
    logic [10:0]       ex;
    logic [51:0]       fr;
    logic [52:0]       sig;
    logic [WIDE_W-1:0] scaled;
    logic [WIDE_W-1:0] cube;
    logic [WIDE_W-1:0] trial;
    logic [53:0]       root;
    logic [53:0]       cand;
    logic [53:0]       mant;
    logic              sticky;
    int                e2;
    int                t;
    int                rm;
    int                q;
    sgn = v[63];
    ex  = v[62:52];
    fr  = v[51:0];
    if (ex == 11'h7FF) begin
      if (fr == '0) return v;
      return v | 64'h0008_0000_0000_0000;
    end
    if (ex == '0 && fr == '0) return v;
    // normalize the significand into [2^52, 2^53)
    if (ex == '0) begin
      sig = {1'b0, fr};
      e2  = -1074;
      while (!sig[52]) begin
        sig = sig << 1;
        e2  = e2 - 1;
      end
    end else begin
      sig = {1'b1, fr};
      e2  = int'(ex) - 1075;
    end
    t  = e2 + 52;
    rm = ((t % 3) + 3) % 3;
    q  = (t - rm) / 3;
    scaled = WIDE_W'(sig) << (107 + rm);
    // resolve 54 root bits, most significant first
    root = '0;
    for (int b = 53; b >= 0; b--) begin
      cand  = root | (54'd1 << b);
      trial = WIDE_W'(cand);
      cube  = trial * trial * trial;
      if (cube <= scaled) root = cand;
    end
    trial  = WIDE_W'(root);
    cube   = trial * trial * trial;
    sticky = (cube != scaled);
    mant   = root >> 1;
    if (root[0] && (sticky || mant[0])) mant = mant + 1;
    if (mant[53]) begin
      mant = mant >> 1;
      q    = q + 1;
    end
    return {sgn, 11'(q + 1023), mant[51:0]};
  endfunction

  class root_scoreboard;
    logic [63:0] pending_roots[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_request(logic [63:0] op);
      pending_roots.push_back(cbrt_round_nearest(op));
    endfunction

    function void check_root(logic [63:0] got);
      logic [63:0] want;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected root %h", got);
        return;
      end
      want = pending_roots.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("root_bits mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_operand_bits;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_root_bits;

  root_scoreboard roots_sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             hold_request;
  int             hold_left;
  int             quiet_cycles;

  cube_root_double_rounded u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operand_bits(in_operand_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_root_bits  (out_root_bits)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random stalls, plus one long hold when asked
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check each accepted root
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) roots_sb.check_root(out_root_bits);
  end

  // watchdog: count cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request, idling first at random; returns after the negedge
  task automatic send_request(logic [63:0] op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operand_bits <= op;
    do @(posedge clk); while (!in_ready);
    roots_sb.note_request(op);
    @(negedge clk);
  endtask

  // random operand, weighted toward normal values across the exponent range
  function automatic logic [63:0] random_operand();
    logic [63:0] r;
    int          kind;
    r    = {$urandom, $urandom};
    kind = $urandom_range(99);
    if (kind < 65) begin
      r[62:52] = 11'($urandom_range(2046, 1));
    end else if (kind < 80) begin
      r[62:52] = '0;
      if ($urandom_range(1)) r[51:0] = r[51:0] >> $urandom_range(51);
    end else if (kind < 85) begin
      r[62:52] = 11'h7FF;
      if ($urandom_range(1)) r[51:0] = '0;
    end else if (kind < 88) begin
      r[62:0] = '0;
    end else if (kind < 94) begin
      // exact cubes of small integers and their neighbors
      r = $realtobits(real'(longint'($urandom_range(2000)) ** 3));
      r = r + 64'($urandom_range(2)) - 64'd1;
      r[63] = 1'($urandom_range(1));
    end
    return r;
  endfunction

  logic [63:0] directed_ops[] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
    64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
    64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001,
    64'hFFF5_5555_AAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
    64'h0010_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
    64'hFFEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
    64'h4020_0000_0000_0000, 64'h403B_0000_0000_0000,
    64'hC020_0000_0000_0000, 64'h3FC0_0000_0000_0000,
    64'h4000_0000_0000_0000, 64'h4008_0000_0000_0000,
    64'h0008_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
  };

  initial begin
    roots_sb        = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operand_bits = '0;
    out_ready       = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_request    = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners, no idling
    foreach (directed_ops[i]) send_request(directed_ops[i]);

    // random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      // back the pipeline up while the sender keeps offering
      if (phase == 0) hold_request = LONG_HOLD;
      for (int n = 0; n < 120; n++) send_request(random_operand());
    end
    in_valid <= 1'b0;

    // drain
    while (roots_sb.pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (roots_sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
